// ===== hdl/stt_pkg.sv =====
// Shared types and constants for the sorted table unit.
`timescale 1ns / 1ps

package stt_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int VAL_W  = 32;
    localparam int CMD_W  = 2;
    localparam int POS_W  = 6;
    localparam int IDX_W  = 7;
    localparam int STAT_W = 2;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEARCH = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] key;
        logic [CNT_W-1:0]        count;
        logic [POS_W-1:0]        del_pos;
        logic                    ins_en;
        logic                    del_en;
    } cell_ctl_t;

endpackage

// ===== hdl/stt_in_if.sv =====
// Command channel interface of the sorted table unit.
`timescale 1ns / 1ps

interface stt_in_if;
    logic                              valid;
    logic                              ready;
    logic [stt_pkg::CMD_W-1:0]         cmd;
    logic signed [stt_pkg::VAL_W-1:0]  value;
    logic [stt_pkg::POS_W-1:0]         position;

    modport source (output valid, output cmd, output value, output position, input ready);
    modport sink (input valid, input cmd, input value, input position, output ready);
endinterface

// ===== hdl/stt_out_if.sv =====
// Result channel interface of the sorted table unit.
`timescale 1ns / 1ps

interface stt_out_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [stt_pkg::IDX_W-1:0]  index;
    logic [stt_pkg::IDX_W-1:0]  entries;
    logic [stt_pkg::STAT_W-1:0] status;

    modport source (output valid, output found, output index, output entries, output status,
                    input ready);
    modport sink (input valid, input found, input index, input entries, input status,
                  output ready);
endinterface

// ===== hdl/stt_cell.sv =====
// One table cell: holds an entry, compares it with the key and shifts with its neighbors.
`timescale 1ns / 1ps

module stt_cell
(
    input  logic                             clk,
    input  logic [stt_pkg::ADDR_W-1:0]       idx,
    input  stt_pkg::cell_ctl_t               ctl,
    input  logic                             left_lt,
    input  logic signed [stt_pkg::VAL_W-1:0] left_data,
    input  logic signed [stt_pkg::VAL_W-1:0] right_data,
    output logic signed [stt_pkg::VAL_W-1:0] data,
    output logic                             lt,
    output logic                             eq
);

    logic signed [stt_pkg::VAL_W-1:0] data_reg;
    logic signed [stt_pkg::VAL_W-1:0] data_next;
    logic                             lt_reg;
    logic                             lt_next;
    logic                             eq_reg;
    logic                             eq_next;
    logic                             in_use;
    logic                             at_or_after_pos;

    assign in_use          = stt_pkg::CNT_W'(idx) < ctl.count;
    assign at_or_after_pos = stt_pkg::CMP_W'(idx) >= stt_pkg::CMP_W'(ctl.del_pos);
    assign lt_next         = in_use && (data_reg < ctl.key);
    assign eq_next         = in_use && (data_reg == ctl.key);

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins_en)
        begin
            if (!left_lt)
            begin
                data_next = left_data;
            end
            else if (!lt_reg)
            begin
                data_next = ctl.key;
            end
        end
        else if (ctl.del_en && at_or_after_pos)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        lt_reg   <= lt_next;
        eq_reg   <= eq_next;
    end

    assign data = data_reg;
    assign lt   = lt_reg;
    assign eq   = eq_reg;

endmodule

// ===== hdl/sorted_table_insert_delete_search_unit.sv =====
// Sorted table unit: a row of compare-and-shift cells under a small command controller.
//
// Commands arrive on in_ch, one transfer each: search-and-insert, delete at a position,
// or lookup, or no operation. Every command gives exactly one result transfer on out_ch with the
// found flag, the index, the number of entries in use and a status code.
// At the transfer of a command every cell compares its entry with the value; in the execute
// state the controller reads the row of compare flags, decides, shifts the cells and loads
// the result register. A new command is taken only after the execute state ends, so the
// cell row is used by one command at a time.
// A new command may be taken while an earlier result still waits on out_ch. If the
// receiver stalls, the finished command holds in its execute cycle until the result
// register frees, and in_ch stays not ready meanwhile.
// Reset empties the table at once (the entry count goes to zero); the cells need no
// clearing, since only entries below the count are ever read.
`timescale 1ns / 1ps

module sorted_table_insert_delete_search_unit
(
    input  logic      clk,
    input  logic      rst_n,
    stt_in_if.sink    in_ch,
    stt_out_if.source out_ch
);

    stt_pkg::state_t                  state_reg;
    stt_pkg::state_t                  state_next;
    stt_pkg::cmd_t                    cmd_reg;
    logic signed [stt_pkg::VAL_W-1:0] value_reg;
    logic [stt_pkg::POS_W-1:0]        pos_reg;
    logic [stt_pkg::CNT_W-1:0]        count_reg;
    logic [stt_pkg::CNT_W-1:0]        count_next;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             found_reg;
    logic [stt_pkg::IDX_W-1:0]        index_reg;
    logic [stt_pkg::IDX_W-1:0]        entries_reg;
    stt_pkg::status_t                 status_reg;

    logic                             in_fire;
    logic                             exec_fire;
    stt_pkg::cell_ctl_t               ctl;

    logic                             lt_w   [stt_pkg::DEPTH];
    logic                             eq_w   [stt_pkg::DEPTH];
    logic signed [stt_pkg::VAL_W-1:0] data_w [stt_pkg::DEPTH];

    logic [stt_pkg::DEPTH-1:0]        eq_vec;
    logic [stt_pkg::CNT_W-1:0]        smaller;
    logic                             hit;
    logic                             full;
    logic                             pos_out;
    logic                             do_ins;
    logic                             do_del;
    logic                             r_found;
    logic [stt_pkg::IDX_W-1:0]        r_index;
    stt_pkg::status_t                 r_status;

    assign in_ch.ready = (state_reg == stt_pkg::S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign exec_fire   = (state_reg == stt_pkg::S_EXEC) && (!out_valid_reg || out_ch.ready);

    genvar k;
    generate
        for (k = 0; k < stt_pkg::DEPTH; k++)
        begin : g_cell
            logic                             left_lt;
            logic signed [stt_pkg::VAL_W-1:0] left_data;
            logic signed [stt_pkg::VAL_W-1:0] right_data;

            if (k == 0)
            begin : g_first
                assign left_lt   = 1'b1;
                assign left_data = ctl.key;
            end
            else
            begin : g_mid
                assign left_lt   = lt_w[k-1];
                assign left_data = data_w[k-1];
            end

            if (k == stt_pkg::DEPTH - 1)
            begin : g_last
                assign right_data = data_w[k];
            end
            else
            begin : g_inner
                assign right_data = data_w[k+1];
            end

            stt_cell u_cell
            (
                .clk        (clk),
                .idx        (stt_pkg::ADDR_W'(k)),
                .ctl        (ctl),
                .left_lt    (left_lt),
                .left_data  (left_data),
                .right_data (right_data),
                .data       (data_w[k]),
                .lt         (lt_w[k]),
                .eq         (eq_w[k])
            );

            assign eq_vec[k] = eq_w[k];
        end
    endgenerate

    // The compare flags form a thermometer code; its edge gives the count of smaller entries.
    always_comb
    begin
        smaller = '0;
        for (int i = 0; i < stt_pkg::DEPTH; i++)
        begin
            if (((i == 0) || lt_w[(i == 0) ? 0 : i - 1]) && !lt_w[i])
            begin
                smaller = smaller | stt_pkg::CNT_W'(i);
            end
        end
        if (lt_w[stt_pkg::DEPTH-1])
        begin
            smaller = smaller | stt_pkg::CNT_W'(stt_pkg::DEPTH);
        end
    end

    assign hit     = |eq_vec;
    assign full    = (count_reg == stt_pkg::CNT_W'(stt_pkg::DEPTH));
    assign pos_out = stt_pkg::CMP_W'(pos_reg) >= stt_pkg::CMP_W'(count_reg);

    always_comb
    begin
        r_found  = 1'b0;
        r_index  = '0;
        r_status = stt_pkg::STAT_OK;
        do_ins   = 1'b0;
        do_del   = 1'b0;
        unique case (cmd_reg)
            stt_pkg::CMD_SEARCH:
            begin
                r_found = hit;
                r_index = stt_pkg::IDX_W'(smaller);
                if (!hit)
                begin
                    if (full)
                    begin
                        r_status = stt_pkg::STAT_FULL;
                    end
                    else
                    begin
                        do_ins = 1'b1;
                    end
                end
            end
            stt_pkg::CMD_DELETE:
            begin
                r_index = stt_pkg::IDX_W'(pos_reg);
                if (pos_out)
                begin
                    r_status = stt_pkg::STAT_RANGE;
                end
                else
                begin
                    do_del = 1'b1;
                end
            end
            stt_pkg::CMD_LOOKUP:
            begin
                r_found = hit;
                if (hit || (smaller == '0))
                begin
                    r_index = stt_pkg::IDX_W'(smaller);
                end
                else
                begin
                    r_index = stt_pkg::IDX_W'(smaller - stt_pkg::CNT_W'(1));
                end
            end
            stt_pkg::CMD_NONE:
            begin
                r_found = 1'b0;
            end
            default:
            begin
                r_found = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ctl.key     = (state_reg == stt_pkg::S_IDLE) ? in_ch.value : value_reg;
        ctl.count   = count_reg;
        ctl.del_pos = pos_reg;
        ctl.ins_en  = exec_fire && do_ins;
        ctl.del_en  = exec_fire && do_del;
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.ins_en)
        begin
            count_next = count_reg + stt_pkg::CNT_W'(1);
        end
        else if (ctl.del_en)
        begin
            count_next = count_reg - stt_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stt_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = stt_pkg::S_EXEC;
                end
            end
            stt_pkg::S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = stt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = stt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stt_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg   <= stt_pkg::cmd_t'(in_ch.cmd);
            value_reg <= in_ch.value;
            pos_reg   <= in_ch.position;
        end
        if (exec_fire)
        begin
            found_reg   <= r_found;
            index_reg   <= r_index;
            entries_reg <= stt_pkg::IDX_W'(count_next);
            status_reg  <= r_status;
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.found   = found_reg;
    assign out_ch.index   = index_reg;
    assign out_ch.entries = entries_reg;
    assign out_ch.status  = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= stt_pkg::CNT_W'(stt_pkg::DEPTH))
        else $error("Entry count exceeds the table depth.");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == stt_pkg::S_EXEC))
        else $error("Accepted command did not move to execution.");

    a_count_moves_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(exec_fire))
        else $error("Entry count changed outside an execution cycle.");

    a_found_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> (status_reg == stt_pkg::STAT_OK))
        else $error("Result reports a hit together with an error status.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> out_valid_reg && $stable(index_reg))
        else $error("Pending result was lost or changed while stalled.");

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the sorted table unit: directed and random commands checked against a predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 300;
    localparam int MAX_PRINTED    = 20;

    typedef struct {
        logic                        found;
        logic [stt_pkg::IDX_W-1:0]   index;
        logic [stt_pkg::IDX_W-1:0]   entries;
        logic [stt_pkg::STAT_W-1:0]  status;
    } table_result_t;

    logic clk;
    logic rst_n;

    stt_in_if  in_ch();
    stt_out_if out_ch();

    sorted_table_insert_delete_search_unit u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    logic signed [stt_pkg::VAL_W-1:0] shadow_table [stt_pkg::DEPTH];
    int                               shadow_count;
    table_result_t                    awaited_results [$];

    int error_count;
    int idle_pct;
    int stall_pct;
    int hold_asked;
    int hold_served;
    int hold_left;
    int quiet_cycles;

    int n_commands;
    int n_inserts;
    int n_hits;
    int n_full;
    int n_range;
    int n_deletes;
    int n_lookups;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Applies one command to the shadow table and returns the result the unit must give.
    function automatic table_result_t apply_table_cmd(stt_pkg::cmd_t c,
                                                      logic signed [stt_pkg::VAL_W-1:0] v,
                                                      logic [stt_pkg::POS_W-1:0] p);
        table_result_t r;
        int            lb;
        int            k;
        r.found  = 1'b0;
        r.index  = '0;
        r.status = stt_pkg::STAT_OK;
        lb = 0;
        if (c == stt_pkg::CMD_SEARCH || c == stt_pkg::CMD_LOOKUP)
        begin
            while (lb < shadow_count && shadow_table[lb] < v)
                lb++;
        end
        case (c)
            stt_pkg::CMD_SEARCH:
            begin
                r.index = lb[stt_pkg::IDX_W-1:0];
                if (lb < shadow_count && shadow_table[lb] == v)
                begin
                    r.found = 1'b1;
                end
                else if (shadow_count >= stt_pkg::DEPTH)
                begin
                    r.status = stt_pkg::STAT_FULL;
                end
                else
                begin
                    for (k = shadow_count; k > lb; k--)
                        shadow_table[k] = shadow_table[k-1];
                    shadow_table[lb] = v;
                    shadow_count++;
                end
            end
            stt_pkg::CMD_DELETE:
            begin
                r.index = {1'b0, p};
                if (int'(p) >= shadow_count)
                begin
                    r.status = stt_pkg::STAT_RANGE;
                end
                else
                begin
                    for (k = int'(p); k + 1 < shadow_count; k++)
                        shadow_table[k] = shadow_table[k+1];
                    shadow_count--;
                end
            end
            stt_pkg::CMD_LOOKUP:
            begin
                if (lb < shadow_count && shadow_table[lb] == v)
                begin
                    r.found = 1'b1;
                    r.index = lb[stt_pkg::IDX_W-1:0];
                end
                else
                begin
                    r.index = (lb > 0) ? stt_pkg::IDX_W'(lb - 1) : '0;
                end
            end
            default:
            begin
            end
        endcase
        r.entries = shadow_count[stt_pkg::IDX_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Offers one command, waits for its transfer, records the prediction, then maybe idles.
    task automatic send_cmd(stt_pkg::cmd_t c, logic signed [stt_pkg::VAL_W-1:0] v,
                            logic [stt_pkg::POS_W-1:0] p);
        table_result_t r;
        in_ch.valid    <= 1'b1;
        in_ch.cmd      <= c;
        in_ch.value    <= v;
        in_ch.position <= p;
        do
            @(posedge clk);
        while (!in_ch.ready);
        r = apply_table_cmd(c, v, p);
        awaited_results.push_back(r);
        n_commands++;
        if (c == stt_pkg::CMD_DELETE)
            n_deletes++;
        if (c == stt_pkg::CMD_LOOKUP)
            n_lookups++;
        if (r.found)
            n_hits++;
        if (c == stt_pkg::CMD_SEARCH && !r.found && r.status == stt_pkg::STAT_OK)
            n_inserts++;
        if (r.status == stt_pkg::STAT_FULL)
            n_full++;
        if (r.status == stt_pkg::STAT_RANGE)
            n_range++;
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stops offering commands and waits until every expected result has been checked.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [stt_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3, 4: return stt_pkg::VAL_W'(int'($urandom_range(32)) - 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [stt_pkg::VAL_W-1:0] pick_stored_value();
        if (shadow_count == 0)
            return pick_value();
        return shadow_table[$urandom_range(shadow_count - 1)];
    endfunction

    // One random command; insert_weight and delete_weight shift the mix toward growth or shrink.
    task automatic send_random_cmd(int insert_weight, int delete_weight);
        int roll;
        int pos;
        roll = $urandom_range(99);
        if (roll < insert_weight)
        begin
            send_cmd(stt_pkg::CMD_SEARCH, pick_value(), stt_pkg::POS_W'($urandom));
        end
        else if (roll < insert_weight + delete_weight)
        begin
            if (shadow_count > 0 && $urandom_range(3) != 0)
                pos = $urandom_range(shadow_count - 1);
            else
                pos = $urandom_range(stt_pkg::DEPTH - 1);
            send_cmd(stt_pkg::CMD_DELETE, $urandom, stt_pkg::POS_W'(pos));
        end
        else
        begin
            roll = $urandom_range(99);
            if (roll < 30)
                send_cmd(stt_pkg::CMD_SEARCH, pick_stored_value(), stt_pkg::POS_W'($urandom));
            else if (roll < 60)
                send_cmd(stt_pkg::CMD_LOOKUP, pick_stored_value(), stt_pkg::POS_W'($urandom));
            else if (roll < 92)
                send_cmd(stt_pkg::CMD_LOOKUP, pick_value(), stt_pkg::POS_W'($urandom));
            else
                send_cmd(stt_pkg::CMD_NONE, $urandom, stt_pkg::POS_W'($urandom));
        end
    endtask

    task automatic test_directed();
        send_cmd(stt_pkg::CMD_LOOKUP, 32'sd0, 6'd0);
        send_cmd(stt_pkg::CMD_DELETE, 32'sd0, 6'd0);
        send_cmd(stt_pkg::CMD_NONE, 32'sd0, 6'd0);
        send_cmd(stt_pkg::CMD_SEARCH, 32'sd0, 6'd0);
        send_cmd(stt_pkg::CMD_SEARCH, 32'sh8000_0000, 6'd0);
        send_cmd(stt_pkg::CMD_SEARCH, 32'sh7fff_ffff, 6'd63);
        send_cmd(stt_pkg::CMD_SEARCH, -32'sd1, 6'd0);
        send_cmd(stt_pkg::CMD_SEARCH, 32'sd0, 6'd0);
        send_cmd(stt_pkg::CMD_SEARCH, 32'sh8000_0000, 6'd0);
        send_cmd(stt_pkg::CMD_LOOKUP, 32'sh7fff_ffff, 6'd0);
        send_cmd(stt_pkg::CMD_LOOKUP, 32'sd5, 6'd0);
        send_cmd(stt_pkg::CMD_LOOKUP, 32'sh8000_0001, 6'd0);
        send_cmd(stt_pkg::CMD_DELETE, 32'sd0, 6'd63);
        send_cmd(stt_pkg::CMD_DELETE, 32'sd0, 6'd3);
        send_cmd(stt_pkg::CMD_DELETE, 32'sd0, 6'd0);
        send_cmd(stt_pkg::CMD_LOOKUP, 32'sh7fff_ffff, 6'd0);
        send_cmd(stt_pkg::CMD_NONE, 32'shffff_ffff, 6'd63);
        send_cmd(stt_pkg::CMD_DELETE, 32'sd0, 6'd4);
        send_cmd(stt_pkg::CMD_DELETE, 32'sd0, 6'd1);
        send_cmd(stt_pkg::CMD_DELETE, 32'sd0, 6'd0);
        send_cmd(stt_pkg::CMD_LOOKUP, 32'sh8000_0000, 6'd0);
        wait_drained();
    endtask

    task automatic test_fill_to_full();
        while (shadow_count < stt_pkg::DEPTH)
            send_cmd(stt_pkg::CMD_SEARCH, pick_value(), stt_pkg::POS_W'($urandom));
        repeat (12)
            send_cmd(stt_pkg::CMD_SEARCH, pick_value(), stt_pkg::POS_W'($urandom));
        repeat (8)
            send_cmd(stt_pkg::CMD_SEARCH, pick_stored_value(), stt_pkg::POS_W'($urandom));
        repeat (8)
            send_cmd(stt_pkg::CMD_LOOKUP, pick_value(), stt_pkg::POS_W'($urandom));
        send_cmd(stt_pkg::CMD_DELETE, 32'sd0, 6'd63);
        send_cmd(stt_pkg::CMD_SEARCH, 32'sh7fff_fffe, 6'd0);
        wait_drained();
    endtask

    task automatic test_random_mix(int n, int insert_weight, int delete_weight);
        repeat (n)
            send_random_cmd(insert_weight, delete_weight);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_asked++;
        repeat (30)
            send_random_cmd(40, 30);
        wait_drained();
        repeat (20)
            send_random_cmd(40, 30);
        wait_drained();
    endtask

    task automatic test_drain_to_empty();
        while (shadow_count > 0)
            send_cmd(stt_pkg::CMD_DELETE, $urandom,
                     stt_pkg::POS_W'($urandom_range(shadow_count - 1)));
        send_cmd(stt_pkg::CMD_LOOKUP, pick_value(), 6'd0);
        send_cmd(stt_pkg::CMD_DELETE, 32'sd0, 6'd0);
        wait_drained();
    endtask

    task automatic set_idling(int sender_pct, int receiver_pct);
        idle_pct  = sender_pct;
        stall_pct = receiver_pct;
    endtask

    initial
    begin
        out_ch.ready <= 1'b0;
        hold_left = 0;
        hold_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_asked)
            begin
                hold_served = hold_asked;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch("unexpected result transfer", 1, 0);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (out_ch.found !== want.found)
                    report_mismatch("found", out_ch.found, want.found);
                if (out_ch.index !== want.index)
                    report_mismatch("index", out_ch.index, want.index);
                if (out_ch.entries !== want.entries)
                    report_mismatch("entries", out_ch.entries, want.entries);
                if (out_ch.status !== want.status)
                    report_mismatch("status", out_ch.status, want.status);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding",
                     awaited_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.cmd      <= stt_pkg::CMD_SEARCH;
        in_ch.value    <= '0;
        in_ch.position <= '0;
        quiet_cycles   <= 0;
        error_count  = 0;
        shadow_count = 0;
        hold_asked   = 0;
        n_commands   = 0;
        n_inserts    = 0;
        n_hits       = 0;
        n_full       = 0;
        n_range      = 0;
        n_deletes    = 0;
        n_lookups    = 0;
        set_idling(0, 0);
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_to_full();
        set_idling(0, 0);
        test_random_mix(120, 30, 30);
        set_idling(62, 0);
        test_random_mix(120, 40, 20);
        set_idling(0, 62);
        test_random_mix(120, 20, 40);
        set_idling(26, 26);
        test_random_mix(120, 30, 30);
        set_idling(0, 0);
        test_backpressure();
        set_idling(26, 26);
        test_drain_to_empty();

        wait_drained();
        repeat (20)
            @(posedge clk);

        if (awaited_results.size() != 0)
            report_mismatch("results still outstanding", awaited_results.size(), 0);
        $display("%0d commands: %0d inserts, %0d hits, %0d deletes, %0d lookups",
                 n_commands, n_inserts, n_hits, n_deletes, n_lookups);
        $display("%0d full-table rejections, %0d out-of-range deletes, %0d mismatches",
                 n_full, n_range, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
